### design/rba_pkg.sv
package rba_pkg;

  // Word formats: Q16.16 coordinates and Q2.30 rotation values share one width.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned WIDE_W = 40;
  localparam int unsigned PROD_W = 64;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  typedef word_t [2:0] vec3_t;
  typedef vec3_t [2:0] mat_t;

  // One vertex word on the input channel.
  typedef struct packed {
    word_t vertex_x;
    word_t vertex_y;
    word_t vertex_z;
    logic  last_vertex;
  } vertex_t;

  // One bounds word on the output channel.
  typedef struct packed {
    word_t upper_x;
    word_t upper_y;
    word_t upper_z;
    word_t lower_x;
    word_t lower_y;
    word_t lower_z;
  } bounds_t;

  typedef struct packed {
    word_t w;
    word_t x;
    word_t y;
    word_t z;
  } quat_t;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    REG_ROT_W = 3'd0,
    REG_ROT_X = 3'd1,
    REG_ROT_Y = 3'd2,
    REG_ROT_Z = 3'd3,
    REG_POS_X = 3'd4,
    REG_POS_Y = 3'd5,
    REG_POS_Z = 3'd6
  } reg_idx_t;

  // Matrix builder sequencer.
  typedef enum logic [1:0] {
    MX_MUL,
    MX_TERM,
    MX_COMB,
    MX_READY
  } mx_state_t;

  // Transform and bounds sequencer.
  typedef enum logic [2:0] {
    BK_MUL0,
    BK_MUL1,
    BK_MUL2,
    BK_SUM2,
    BK_EMIT
  } bk_state_t;

  localparam word_t ONE_Q30    = 32'sh4000_0000;
  localparam word_t MARGIN_Q16 = 32'sd6554;
  localparam word_t WORD_MAX   = 32'sh7FFF_FFFF;
  localparam word_t WORD_MIN   = 32'sh8000_0000;

  // Clamp a wide signed value to the signed word range.
  function automatic word_t sat_word(wide_t v);
    word_t r;
    if (v > wide_t'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < wide_t'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  // Divide a product by 2^s, rounding to nearest with halves going up.
  function automatic wide_t round_shift(prod_t p, int unsigned s);
    prod_t r;
    r = p + (prod_t'(1) <<< (s - 1));
    r = r >>> s;
    return r[WIDE_W-1:0];
  endfunction

endpackage

### design/rba_fifo.sv
module rba_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rba_pkg::vertex_t  wr_data,
  output logic              full,
  input  logic              pop,
  output rba_pkg::vertex_t  rd_data,
  output logic              not_empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rba_pkg::vertex_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Storage for queued vertex words.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // Pointers wrap at the queue depth; the count tracks occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = slots[rd_ptr];

  // The back end must never take a word from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue popped while empty");

  // Occupancy never goes past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

### design/rba_matrix.sv
module rba_matrix (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  rba_pkg::quat_t  quat,
  output rba_pkg::mat_t   mat,
  output logic            ready
);

  // Product order: each doubled quaternion product gets one multiplier pass.
  localparam logic [3:0] P_YY = 4'd0;
  localparam logic [3:0] P_ZZ = 4'd1;
  localparam logic [3:0] P_XY = 4'd2;
  localparam logic [3:0] P_WZ = 4'd3;
  localparam logic [3:0] P_XZ = 4'd4;
  localparam logic [3:0] P_WY = 4'd5;
  localparam logic [3:0] P_XX = 4'd6;
  localparam logic [3:0] P_YZ = 4'd7;
  localparam logic [3:0] P_WX = 4'd8;
  localparam int unsigned NUM_P = 9;

  rba_pkg::mx_state_t state;
  rba_pkg::mx_state_t state_next;
  logic [3:0]     cnt;
  logic [3:0]     cnt_next;
  rba_pkg::word_t op_a;
  rba_pkg::word_t op_b;
  rba_pkg::prod_t prod;
  logic [3:0]     prod_k;
  rba_pkg::wide_t term [NUM_P];
  rba_pkg::wide_t one;

  // Operand pair for the current pass.
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cnt)
      P_YY: begin op_a = quat.y; op_b = quat.y; end
      P_ZZ: begin op_a = quat.z; op_b = quat.z; end
      P_XY: begin op_a = quat.x; op_b = quat.y; end
      P_WZ: begin op_a = quat.w; op_b = quat.z; end
      P_XZ: begin op_a = quat.x; op_b = quat.z; end
      P_WY: begin op_a = quat.w; op_b = quat.y; end
      P_XX: begin op_a = quat.x; op_b = quat.x; end
      P_YZ: begin op_a = quat.y; op_b = quat.z; end
      P_WX: begin op_a = quat.w; op_b = quat.x; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  // Sequencer: nine multiplier passes, one rounding drain, one combine.
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    unique case (state)
      rba_pkg::MX_MUL: begin
        cnt_next = cnt + 4'd1;
        if (cnt == P_WX) begin
          state_next = rba_pkg::MX_TERM;
        end
      end
      rba_pkg::MX_TERM:  state_next = rba_pkg::MX_COMB;
      rba_pkg::MX_COMB:  state_next = rba_pkg::MX_READY;
      rba_pkg::MX_READY: state_next = rba_pkg::MX_READY;
      default:           state_next = rba_pkg::MX_MUL;
    endcase
    if (start) begin
      state_next = rba_pkg::MX_MUL;
      cnt_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rba_pkg::MX_MUL;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // Multiplier register, then the rounded doubled product (shift by 29).
  always_ff @(posedge clk) begin
    if (state == rba_pkg::MX_MUL) begin
      prod   <= op_a * op_b;
      prod_k <= cnt;
    end
    if ((state == rba_pkg::MX_MUL && cnt != '0) || state == rba_pkg::MX_TERM) begin
      term[prod_k] <= rba_pkg::round_shift(prod, 29);
    end
  end

  assign one = rba_pkg::wide_t'(rba_pkg::ONE_Q30);

  // Combine the terms into the saturated rotation matrix.
  always_ff @(posedge clk) begin
    if (state == rba_pkg::MX_COMB) begin
      mat[0][0] <= rba_pkg::sat_word(one - term[P_YY] - term[P_ZZ]);
      mat[0][1] <= rba_pkg::sat_word(term[P_XY] - term[P_WZ]);
      mat[0][2] <= rba_pkg::sat_word(term[P_XZ] + term[P_WY]);
      mat[1][0] <= rba_pkg::sat_word(term[P_XY] + term[P_WZ]);
      mat[1][1] <= rba_pkg::sat_word(one - term[P_XX] - term[P_ZZ]);
      mat[1][2] <= rba_pkg::sat_word(term[P_YZ] - term[P_WX]);
      mat[2][0] <= rba_pkg::sat_word(term[P_XZ] - term[P_WY]);
      mat[2][1] <= rba_pkg::sat_word(term[P_YZ] + term[P_WX]);
      mat[2][2] <= rba_pkg::sat_word(one - term[P_XX] - term[P_YY]);
    end
  end

  assign ready = (state == rba_pkg::MX_READY);

  // Once built, the matrix holds until the next rebuild.
  a_mat_hold: assert property (@(posedge clk) disable iff (rst)
    (ready && $past(ready)) |-> $stable(mat))
    else $error("matrix changed while marked ready");

endmodule

### design/rba_back.sv
module rba_back (
  input  logic               clk,
  input  logic               rst,
  input  rba_pkg::mat_t      mat,
  input  rba_pkg::vec3_t     pos,
  input  logic               head_valid,
  input  rba_pkg::vertex_t   head,
  output logic               pop,
  output logic               box_valid,
  input  logic               box_ready,
  output rba_pkg::bounds_t   box
);

  rba_pkg::bk_state_t state;
  rba_pkg::bk_state_t state_next;
  logic           mul_en;
  logic [1:0]     mul_row;
  logic           sum_en;
  logic [1:0]     sum_row;
  logic           load;
  logic           last_q;
  rba_pkg::word_t mul_a [3];
  rba_pkg::word_t mul_b [3];
  rba_pkg::prod_t prod [3];
  rba_pkg::word_t pos_sel;
  rba_pkg::wide_t acc;
  rba_pkg::word_t coord;
  rba_pkg::word_t upper [3];
  rba_pkg::word_t lower [3];

  // Sequencer: rows are multiplied one per cycle, each summed in the cycle after.
  always_comb begin
    state_next = state;
    mul_en     = 1'b0;
    mul_row    = 2'd0;
    sum_en     = 1'b0;
    sum_row    = 2'd0;
    load       = 1'b0;
    pop        = 1'b0;
    unique case (state)
      rba_pkg::BK_MUL0: begin
        mul_en = head_valid;
        if (head_valid) begin
          state_next = rba_pkg::BK_MUL1;
        end
      end
      rba_pkg::BK_MUL1: begin
        mul_en     = 1'b1;
        mul_row    = 2'd1;
        sum_en     = 1'b1;
        state_next = rba_pkg::BK_MUL2;
      end
      rba_pkg::BK_MUL2: begin
        mul_en     = 1'b1;
        mul_row    = 2'd2;
        sum_en     = 1'b1;
        sum_row    = 2'd1;
        pop        = 1'b1;
        state_next = rba_pkg::BK_SUM2;
      end
      rba_pkg::BK_SUM2: begin
        sum_en     = 1'b1;
        sum_row    = 2'd2;
        state_next = last_q ? rba_pkg::BK_EMIT : rba_pkg::BK_MUL0;
      end
      rba_pkg::BK_EMIT: begin
        if (!box_valid || box_ready) begin
          load       = 1'b1;
          state_next = rba_pkg::BK_MUL0;
        end
      end
      default: state_next = rba_pkg::BK_MUL0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rba_pkg::BK_MUL0;
    end else begin
      state <= state_next;
    end
  end

  // Three lanes multiply one matrix row by the vertex.
  always_comb begin
    mul_b[0] = head.vertex_x;
    mul_b[1] = head.vertex_y;
    mul_b[2] = head.vertex_z;
    for (int j = 0; j < 3; j++) begin
      mul_a[j] = mat[mul_row][j];
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      for (int j = 0; j < 3; j++) begin
        prod[j] <= mul_a[j] * mul_b[j];
      end
    end
    if (state == rba_pkg::BK_MUL2) begin
      last_q <= head.last_vertex;
    end
  end

  // Rounded row sum plus translation, clamped to a word.
  always_comb begin
    pos_sel = pos[sum_row];
    acc = rba_pkg::wide_t'(pos_sel)
        + rba_pkg::round_shift(prod[0], 30)
        + rba_pkg::round_shift(prod[1], 30)
        + rba_pkg::round_shift(prod[2], 30);
    coord = rba_pkg::sat_word(acc);
  end

  // Running bounds: updated per coordinate, cleared once the result is loaded.
  always_ff @(posedge clk) begin
    if (rst || load) begin
      for (int i = 0; i < 3; i++) begin
        upper[i] <= rba_pkg::WORD_MIN;
        lower[i] <= rba_pkg::WORD_MAX;
      end
    end else if (sum_en) begin
      if (coord > upper[sum_row]) begin
        upper[sum_row] <= coord;
      end
      if (coord < lower[sum_row]) begin
        lower[sum_row] <= coord;
      end
    end
  end

  // Output register holding one bounds word.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (load) begin
      box_valid <= 1'b1;
    end else if (box_ready) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      box.upper_x <= rba_pkg::sat_word(rba_pkg::wide_t'(upper[0])
                                       + rba_pkg::wide_t'(rba_pkg::MARGIN_Q16));
      box.upper_y <= rba_pkg::sat_word(rba_pkg::wide_t'(upper[1])
                                       + rba_pkg::wide_t'(rba_pkg::MARGIN_Q16));
      box.upper_z <= rba_pkg::sat_word(rba_pkg::wide_t'(upper[2])
                                       + rba_pkg::wide_t'(rba_pkg::MARGIN_Q16));
      box.lower_x <= rba_pkg::sat_word(rba_pkg::wide_t'(lower[0])
                                       - rba_pkg::wide_t'(rba_pkg::MARGIN_Q16));
      box.lower_y <= rba_pkg::sat_word(rba_pkg::wide_t'(lower[1])
                                       - rba_pkg::wide_t'(rba_pkg::MARGIN_Q16));
      box.lower_z <= rba_pkg::sat_word(rba_pkg::wide_t'(lower[2])
                                       - rba_pkg::wide_t'(rba_pkg::MARGIN_Q16));
    end
  end

  // A result is only produced for a vertex that closed its shape.
  a_emit_last: assert property (@(posedge clk) disable iff (rst)
    (state == rba_pkg::BK_EMIT) |-> last_q)
    else $error("result stage entered without a last vertex");

  // Loading a result starts the next shape from empty bounds.
  a_clear_after_load: assert property (@(posedge clk) disable iff (rst)
    load |=> (upper[0] == rba_pkg::WORD_MIN && lower[0] == rba_pkg::WORD_MAX
              && upper[2] == rba_pkg::WORD_MIN && lower[2] == rba_pkg::WORD_MAX))
    else $error("bounds not cleared after result");

endmodule

### design/rotated_box_aabb.sv
// Path: an accepted vertex word waits in the queue; the back end multiplies each
// matrix row by it in turn, registers the products and sums each row into the
// bounds registers; after a last vertex the result loads into box once the output
// is free. The back end works on one vertex at a time; the queue takes new vertex
// words while it has room; the three-lane row multiplier and the row-sum stage
// set the pace. Reset and every configuration write rebuild the rotation matrix,
// and vtx_ready stays low until it is done; bounds start empty.
module rotated_box_aabb #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vtx_valid,
  output logic               vtx_ready,
  input  rba_pkg::vertex_t   vtx,
  output logic               box_valid,
  input  logic               box_ready,
  output rba_pkg::bounds_t   box,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  rba_pkg::quat_t   quat;
  rba_pkg::vec3_t   pos;
  rba_pkg::mat_t    mat;
  logic             mat_ready;
  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  rba_pkg::vertex_t head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      quat.w <= rba_pkg::ONE_Q30;
      quat.x <= '0;
      quat.y <= '0;
      quat.z <= '0;
      pos    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rba_pkg::REG_ROT_W: quat.w <= cfg_data;
        rba_pkg::REG_ROT_X: quat.x <= cfg_data;
        rba_pkg::REG_ROT_Y: quat.y <= cfg_data;
        rba_pkg::REG_ROT_Z: quat.z <= cfg_data;
        rba_pkg::REG_POS_X: pos[0] <= cfg_data;
        rba_pkg::REG_POS_Y: pos[1] <= cfg_data;
        rba_pkg::REG_POS_Z: pos[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: take a vertex word once the matrix is built and the queue has room.
  assign vtx_ready = mat_ready && !q_full;
  assign push      = vtx_valid && vtx_ready;

  rba_matrix u_matrix (
    .clk   (clk),
    .rst   (rst),
    .start (cfg_we),
    .quat  (quat),
    .mat   (mat),
    .ready (mat_ready)
  );

  rba_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (vtx),
    .full      (q_full),
    .pop       (pop),
    .rd_data   (head),
    .not_empty (q_valid)
  );

  rba_back u_back (
    .clk        (clk),
    .rst        (rst),
    .mat        (mat),
    .pos        (pos),
    .head_valid (q_valid),
    .head       (head),
    .pop        (pop),
    .box_valid  (box_valid),
    .box_ready  (box_ready),
    .box        (box)
  );

endmodule
